### hw/rtl/s2da_pkg.sv
// Shared constants, types and the BCD adjust function of the decimal text converter.
package s2da_pkg;

    localparam int MAX_DIGITS  = 19;
    localparam int MAG_W       = 64;
    localparam int CHAR_W      = 8;
    localparam int IDX_W       = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W       = $clog2(MAG_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CNT_W-1:0]  CONV_LAST  = CNT_W'(MAG_W - 1);
    localparam logic [IDX_W-1:0]  IDX_TOP    = IDX_W'(MAX_DIGITS - 1);

    typedef struct packed {
        logic             negative;
        logic [MAG_W-1:0] magnitude;
    } item_t;

    // A digit of five or more gains three so that the following doubling carries correctly.
    function automatic logic [3:0] bcd_adjust(input logic [3:0] digit);
        logic [3:0] result;
        begin
            if (digit >= 4'd5)
            begin
                result = digit + 4'd3;
            end
            else
            begin
                result = digit;
            end
            return result;
        end
    endfunction

endpackage

### hw/rtl/signed_to_decimal_ascii.sv
// Top level of the signed 64-bit integer to decimal ASCII text converter.
// Each accepted number comes out as its decimal text, most significant digit first, one
// character per item, with '-' first for a negative value and last set on the final digit;
// zero gives the single character '0'. The front stage and a two-entry queue take numbers
// while the converter is busy. The converter loads a number, runs shift-and-add-three
// conversion, one magnitude bit a cycle, steps past the leading zero digits, then sends one
// character each cycle that the output side accepts. Skipped zeros and digits sent always
// add up to 19.
module signed_to_decimal_ascii (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [63:0]            number,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [s2da_pkg::CHAR_W-1:0]   character,
    output logic                          last
);

    logic            front_valid;
    logic            front_ready;
    s2da_pkg::item_t front_item;
    logic            queue_valid;
    logic            queue_ready;
    s2da_pkg::item_t queue_item;

    s2da_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .number     (number),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    s2da_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    s2da_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (queue_valid),
        .item_ready (queue_ready),
        .item       (queue_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .character  (character),
        .last       (last)
    );

    // A minus sign is never the final character of a number.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (character == s2da_pkg::CHAR_MINUS)) |-> !last)
    else $error("minus sign flagged as last character");

    // Every other character is a decimal digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (character != s2da_pkg::CHAR_MINUS)) |->
        ((character >= s2da_pkg::CHAR_ZERO) && (character <= (s2da_pkg::CHAR_ZERO + 8'd9))))
    else $error("character is neither a sign nor a digit");

    // A digit follows straight after an accepted minus sign.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && (character == s2da_pkg::CHAR_MINUS)) |=>
        (out_valid && (character != s2da_pkg::CHAR_MINUS)))
    else $error("no digit after minus sign");

endmodule

### hw/rtl/s2da_front.sv
// Front stage: accepts a number, records its sign and forms its unsigned magnitude.
module s2da_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [63:0]        number,
    output logic                      item_valid,
    input  logic                      item_ready,
    output s2da_pkg::item_t           item
);

    logic            valid_reg;
    logic            valid_next;
    s2da_pkg::item_t item_reg;
    s2da_pkg::item_t item_next;
    logic            take;

    assign in_ready   = !valid_reg || item_ready;
    assign take       = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (take)
        begin
            valid_next         = 1'b1;
            item_next.negative = number[63];
            if (number[63])
            begin
                item_next.magnitude = ~number + 64'd1;
            end
            else
            begin
                item_next.magnitude = number;
            end
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

### hw/rtl/s2da_queue.sv
// Short queue of classified items between the front stage and the converter.
module s2da_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  s2da_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output s2da_pkg::item_t pop_item
);

    s2da_pkg::item_t                    entry_reg [s2da_pkg::QUEUE_DEPTH];
    logic [s2da_pkg::PTR_W-1:0]         wr_ptr_reg;
    logic [s2da_pkg::PTR_W-1:0]         wr_ptr_next;
    logic [s2da_pkg::PTR_W-1:0]         rd_ptr_reg;
    logic [s2da_pkg::PTR_W-1:0]         rd_ptr_next;
    logic [s2da_pkg::FILL_W-1:0]        fill_reg;
    logic [s2da_pkg::FILL_W-1:0]        fill_next;
    logic                               do_push;
    logic                               do_pop;

    assign push_ready = fill_reg != s2da_pkg::FILL_W'(s2da_pkg::QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hw/rtl/s2da_back.sv
// Converter: shift-and-add-three binary to BCD conversion, then character output.
module s2da_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  s2da_pkg::item_t               item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [s2da_pkg::CHAR_W-1:0]   character,
    output logic                          last
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CONV  = 5'b00010,
        ST_SKIP  = 5'b00100,
        ST_SIGN  = 5'b01000,
        ST_DIGIT = 5'b10000
    } state_t;

    state_t                             state_reg;
    state_t                             state_next;
    logic [s2da_pkg::MAG_W-1:0]         mag_reg;
    logic [s2da_pkg::MAG_W-1:0]         mag_next;
    logic                               neg_reg;
    logic                               neg_next;
    logic                               ovf_reg;
    logic                               ovf_next;
    logic [3:0]                         bcd_reg [s2da_pkg::MAX_DIGITS];
    logic [3:0]                         bcd_next [s2da_pkg::MAX_DIGITS];
    logic [3:0]                         bcd_adj [s2da_pkg::MAX_DIGITS];
    logic [s2da_pkg::CNT_W-1:0]         cnt_reg;
    logic [s2da_pkg::CNT_W-1:0]         cnt_next;
    logic [s2da_pkg::IDX_W-1:0]         idx_reg;
    logic [s2da_pkg::IDX_W-1:0]         idx_next;
    logic [3:0]                         cur_digit;

    assign item_ready = state_reg == ST_IDLE;
    assign cur_digit  = bcd_reg[idx_reg];
    assign out_valid  = (state_reg == ST_SIGN) || (state_reg == ST_DIGIT);

    always_comb
    begin
        if (state_reg == ST_SIGN)
        begin
            character = s2da_pkg::CHAR_MINUS;
            last      = 1'b0;
        end
        else
        begin
            character = s2da_pkg::CHAR_ZERO + {4'b0000, cur_digit};
            last      = idx_reg == '0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < s2da_pkg::MAX_DIGITS; i++)
        begin
            bcd_adj[i] = s2da_pkg::bcd_adjust(bcd_reg[i]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        for (int i = 0; i < s2da_pkg::MAX_DIGITS; i++)
        begin
            bcd_next[i] = bcd_reg[i];
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    mag_next   = item.magnitude;
                    neg_next   = item.negative;
                    ovf_next   = 1'b0;
                    cnt_next   = '0;
                    idx_next   = s2da_pkg::IDX_TOP;
                    state_next = ST_CONV;
                    for (int i = 0; i < s2da_pkg::MAX_DIGITS; i++)
                    begin
                        bcd_next[i] = 4'd0;
                    end
                end
            end
            ST_CONV:
            begin
                bcd_next[0] = {bcd_adj[0][2:0], mag_reg[s2da_pkg::MAG_W-1]};
                for (int i = 1; i < s2da_pkg::MAX_DIGITS; i++)
                begin
                    bcd_next[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
                end
                // A carry out of the top digit means the value has more digits than are kept.
                ovf_next = ovf_reg || bcd_adj[s2da_pkg::MAX_DIGITS-1][3];
                mag_next = {mag_reg[s2da_pkg::MAG_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == s2da_pkg::CONV_LAST)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if ((idx_reg != '0) && (cur_digit == 4'd0) && !ovf_reg)
                begin
                    idx_next = idx_reg - 1'b1;
                end
                else if (neg_reg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (out_ready)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
        cnt_reg <= cnt_next;
        idx_reg <= idx_next;
        for (int i = 0; i < s2da_pkg::MAX_DIGITS; i++)
        begin
            bcd_reg[i] <= bcd_next[i];
        end
    end

endmodule
